// ===== rtl/meter_reply_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// meter reply frame decoder assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef METER_REPLY_FRAME_DECODER_MACROS_SVH
`define METER_REPLY_FRAME_DECODER_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define MRFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrfd checker: property failed");

// next-cycle implication, quiet while reset is held
`define MRFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrfd checker: property failed");

// next-cycle implication that also holds across reset
`define MRFD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mrfd checker: property failed");

`endif

// ===== rtl/mrfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfd_pkg
// types and constants of the meter reply frame decoder
// ----------------------------------------------------------------------------
package mrfd_pkg;

    localparam int CHANNELS_DEF = 6;

    localparam logic [7:0] ARCHIVE_PERIOD_RST = 8'd10;
    localparam logic [7:0] ARCHIVE_CNT_MAX    = 8'd255;

    localparam logic [7:0] ADDR_POWER  = 8'h01;
    localparam logic [7:0] ADDR_RELAY  = 8'h02;
    localparam logic [7:0] FUNC_RELAY  = 8'h01;
    localparam logic [7:0] COUNT_POWER = 8'd84;
    localparam logic [7:0] COUNT_RELAY = 8'd1;

    localparam logic [6:0] POS_ADDR  = 7'd0;
    localparam logic [6:0] POS_FUNC  = 7'd1;
    localparam logic [6:0] POS_COUNT = 7'd2;
    localparam logic [6:0] POS_MAX   = 7'd127;

    localparam int          CHAN_BYTES = 14;
    localparam logic [3:0]  CHAN_LAST  = 4'd13;

    // reciprocal multipliers: x / d == (x * m) >> s over the full input range
    localparam logic [16:0] DIV100_M16  = 17'd83887;
    localparam int          DIV100_S16  = 23;
    localparam logic [16:0] DIV1000_M16 = 17'd67109;
    localparam int          DIV1000_S16 = 26;
    localparam logic [30:0] DIV100_M32  = 31'd1374389535;
    localparam int          DIV100_S32  = 37;

    typedef enum logic [1:0] {
        MODE_IGNORE = 2'd0,
        MODE_POWER  = 2'd1,
        MODE_RELAY  = 2'd2
    } t_frame_mode;

    typedef enum logic {
        KIND_CHANNEL = 1'b0,
        KIND_RELAY   = 1'b1
    } t_record_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic        record_kind;
        logic [3:0]  channel;
        logic [9:0]  voltage;
        logic [6:0]  current;
        logic [15:0] apparent_power;
        logic [25:0] energy_total;
        logic [6:0]  power_factor;
        logic [9:0]  frequency;
        logic [7:0]  relay_bits;
        logic        archive;
    } t_out_item;

    // unscaled record between the frame parser and the scaling stage
    typedef struct packed {
        logic        record_kind;
        logic [3:0]  channel;
        logic [15:0] voltage_raw;
        logic [15:0] current_raw;
        logic [15:0] apparent_power;
        logic [31:0] energy_raw;
        logic [15:0] power_factor_raw;
        logic [15:0] frequency_raw;
        logic [7:0]  relay_bits;
        logic        archive;
    } t_raw_rec;

endpackage

// ===== rtl/meter_reply_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// meter_reply_frame_decoder
// parses meter reply frames byte by byte into channel and relay records
// ----------------------------------------------------------------------------
// one byte is taken per cycle unless the record path stalls; a record
// passes from the parser register through the scaling multipliers into
// the result register
// a waiting result does not stop input until both record slots are full
// synchronous active-low reset clears all control state, period back to 10
// ----------------------------------------------------------------------------
module meter_reply_frame_decoder
    import mrfd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SHW = (CHAN_BYTES - 1) * 8;

    logic [6:0]    r_pos,      n_pos;
    logic [7:0]    r_addr,     n_addr;
    logic [7:0]    r_func,     n_func;
    t_frame_mode   r_mode,     n_mode;
    logic [CW-1:0] r_ci,       n_ci;
    logic [3:0]    r_k,        n_k;
    logic [SHW-1:0] r_shift,   n_shift;
    logic [7:0]    r_arch_cnt, n_arch_cnt;
    logic          r_arch,     n_arch;
    logic [7:0]    r_period;
    logic          r_s1_valid, n_s1_valid;
    t_raw_rec      r_s1,       n_s1;
    logic          r_out_valid, n_out_valid;

    logic          w_accept;
    logic          w_s1_go;
    logic [6:0]    w_pos;
    logic [7:0]    w_byte;
    logic [7:0]    w_cnt_inc;
    logic          w_emit;
    logic [SHW+7:0] w_full;

    assign w_byte  = i_data.data_byte;
    assign w_pos   = i_data.frame_start ? POS_ADDR : r_pos;
    assign w_s1_go = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || w_s1_go;
    assign w_accept = i_valid && o_ready;
    assign w_cnt_inc = (r_arch_cnt < ARCHIVE_CNT_MAX) ? r_arch_cnt + 8'd1 : r_arch_cnt;
    assign w_full  = {r_shift, w_byte};

    // frame parser next state
    always_comb begin
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_func     = r_func;
        n_mode     = r_mode;
        n_ci       = r_ci;
        n_k        = r_k;
        n_shift    = r_shift;
        n_arch_cnt = r_arch_cnt;
        n_arch     = r_arch;
        if (w_accept) begin
            n_pos = (w_pos < POS_MAX) ? w_pos + 7'd1 : w_pos;
            case (w_pos)
                POS_ADDR: begin
                    n_addr = w_byte;
                    n_mode = MODE_IGNORE;
                    n_ci   = '0;
                end
                POS_FUNC: begin
                    n_func = w_byte;
                end
                POS_COUNT: begin
                    n_k = '0;
                    if (r_addr == ADDR_POWER && w_byte == COUNT_POWER) begin
                        n_mode = MODE_POWER;
                        if (w_cnt_inc >= r_period) begin
                            n_arch     = 1'b1;
                            n_arch_cnt = '0;
                        end else begin
                            n_arch     = 1'b0;
                            n_arch_cnt = w_cnt_inc;
                        end
                    end else if (r_addr == ADDR_RELAY && r_func == FUNC_RELAY &&
                                 w_byte == COUNT_RELAY) begin
                        n_mode = MODE_RELAY;
                    end else begin
                        n_mode = MODE_IGNORE;
                    end
                end
                default: begin
                    case (r_mode)
                        MODE_POWER: begin
                            n_shift = {r_shift[SHW-9:0], w_byte};
                            if (r_k == CHAN_LAST) begin
                                n_k = '0;
                                if (r_ci == CW'(CHANNELS - 1)) begin
                                    n_mode = MODE_IGNORE;
                                end else begin
                                    n_ci = r_ci + CW'(1);
                                end
                            end else begin
                                n_k = r_k + 4'd1;
                            end
                        end
                        MODE_RELAY: begin
                            n_mode = MODE_IGNORE;
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase
                end
            endcase
        end
    end

    // record build and handshake
    always_comb begin
        n_s1 = r_s1;
        w_emit = 1'b0;
        if (w_accept && w_pos > POS_COUNT) begin
            case (r_mode)
                MODE_POWER: begin
                    if (r_k == CHAN_LAST) begin
                        w_emit                = 1'b1;
                        n_s1.record_kind      = KIND_CHANNEL;
                        n_s1.channel          = 4'(r_ci) + 4'd1;
                        n_s1.voltage_raw      = w_full[111:96];
                        n_s1.current_raw      = w_full[95:80];
                        n_s1.apparent_power   = w_full[79:64];
                        n_s1.energy_raw       = w_full[63:32];
                        n_s1.power_factor_raw = w_full[31:16];
                        n_s1.frequency_raw    = w_full[15:0];
                        n_s1.relay_bits       = '0;
                        n_s1.archive          = r_arch;
                    end
                end
                MODE_RELAY: begin
                    w_emit = 1'b1;
                    n_s1   = '0;
                    n_s1.record_kind = KIND_RELAY;
                    n_s1.relay_bits  = w_byte;
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
        if (w_emit) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_go) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
        if (w_s1_go) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_addr      <= '0;
            r_func      <= '0;
            r_mode      <= MODE_IGNORE;
            r_ci        <= '0;
            r_k         <= '0;
            r_arch_cnt  <= '0;
            r_arch      <= 1'b0;
            r_period    <= ARCHIVE_PERIOD_RST;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_addr      <= n_addr;
            r_func      <= n_func;
            r_mode      <= n_mode;
            r_ci        <= n_ci;
            r_k         <= n_k;
            r_arch_cnt  <= n_arch_cnt;
            r_arch      <= n_arch;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_s1    <= n_s1;
    end

    mrfd_scale u_scale (
        .i_clk  (i_clk),
        .i_load (w_s1_go),
        .i_raw  (r_s1),
        .o_data (o_data)
    );

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/mrfd_scale.sv =====
// ----------------------------------------------------------------------------
// mrfd_scale
// result register: divides the raw channel words by their constant scales
// ----------------------------------------------------------------------------
module mrfd_scale
    import mrfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_load,
    input  t_raw_rec  i_raw,
    output t_out_item o_data
);

    logic [32:0] w_volt_prod;
    logic [32:0] w_curr_prod;
    logic [32:0] w_pf_prod;
    logic [32:0] w_freq_prod;
    logic [62:0] w_energy_prod;
    t_out_item   n_out;
    t_out_item   r_out;

    assign w_volt_prod   = 33'(i_raw.voltage_raw) * 33'(DIV100_M16);
    assign w_curr_prod   = 33'(i_raw.current_raw) * 33'(DIV1000_M16);
    assign w_pf_prod     = 33'(i_raw.power_factor_raw) * 33'(DIV1000_M16);
    assign w_freq_prod   = 33'(i_raw.frequency_raw) * 33'(DIV100_M16);
    assign w_energy_prod = 63'(i_raw.energy_raw) * 63'(DIV100_M32);

    always_comb begin
        n_out.record_kind    = i_raw.record_kind;
        n_out.channel        = i_raw.channel;
        n_out.voltage        = w_volt_prod[DIV100_S16 +: 10];
        n_out.current        = w_curr_prod[DIV1000_S16 +: 7];
        n_out.apparent_power = i_raw.apparent_power;
        n_out.energy_total   = w_energy_prod[DIV100_S32 +: 26];
        n_out.power_factor   = w_pf_prod[DIV1000_S16 +: 7];
        n_out.frequency      = w_freq_prod[DIV100_S16 +: 10];
        n_out.relay_bits     = i_raw.relay_bits;
        n_out.archive        = i_raw.archive;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ===== rtl/mrfd_checker.sv =====
// ----------------------------------------------------------------------------
// mrfd_checker
// port-level checks of the meter reply frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "meter_reply_frame_decoder_macros.svh"

module mrfd_checker
    import mrfd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    logic w_out_stall;
    logic w_relay_out;
    logic w_relay_clean;
    logic w_chan_out;
    logic w_chan_ok;

    assign w_out_stall   = i_out_valid && !i_out_ready;
    assign w_relay_out   = i_out_valid && i_out_data.record_kind == KIND_RELAY;
    assign w_relay_clean = i_out_data.channel == 4'd0 && i_out_data.archive == 1'b0 &&
                           i_out_data.voltage == '0 && i_out_data.energy_total == '0;
    assign w_chan_out    = i_out_valid && i_out_data.record_kind == KIND_CHANNEL;
    assign w_chan_ok     = i_out_data.channel != 4'd0 && i_out_data.channel <= 4'(CHANNELS) &&
                           i_out_data.relay_bits == 8'd0 && i_out_data.voltage <= 10'd655 &&
                           i_out_data.current <= 7'd65;

    // a stalled result holds
    `MRFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid && $stable(i_out_data))

    // nothing is shown straight after a reset cycle
    `MRFD_ASSERT_NEXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !i_out_valid)

    // relay record carries only the relay bits
    `MRFD_ASSERT_NOW(a_relay_clean, i_clk, i_rst_n, w_relay_out, w_relay_clean)

    // channel record has a channel in range and scaled values in range
    `MRFD_ASSERT_NOW(a_chan_range, i_clk, i_rst_n, w_chan_out, w_chan_ok)

endmodule

bind meter_reply_frame_decoder mrfd_checker #(
    .CHANNELS (CHANNELS)
) u_mrfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);

// ===== tb/mrfd_record_checker.sv =====
// ----------------------------------------------------------------------------
// mrfd_record_checker
// watches the byte and record channels of the meter reply frame decoder,
// decodes every byte transfer into the records it should produce and
// compares each record transfer, field by field, with the oldest of them
// ----------------------------------------------------------------------------
module mrfd_record_checker
    import mrfd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_channel_records,
    output int         o_relay_records,
    output int         o_archived_records
);

    localparam int FIRST_DATA_POS = int'(POS_COUNT) + 1;

    logic [7:0]  archive_period = ARCHIVE_PERIOD_RST;
    logic [6:0]  byte_pos       = POS_ADDR;
    logic [7:0]  frame_address  = '0;
    logic [7:0]  frame_function = '0;
    t_frame_mode frame_mode     = MODE_IGNORE;
    logic [2:0]  chan_idx       = '0;
    logic [7:0]  chan_bytes [CHAN_BYTES];
    logic [7:0]  archive_cnt    = '0;
    logic        archive_flag   = 1'b0;

    t_out_item decoded_records [$];

    int fails      = 0;
    int chan_seen  = 0;
    int relay_seen = 0;
    int arch_seen  = 0;

    function automatic logic [31:0] word_div(input logic [7:0] hi, input logic [7:0] lo,
                                             input logic [31:0] divisor);
        logic [31:0] word;
        word = {16'd0, hi, lo};
        return word / divisor;
    endfunction

    task compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fails++;
        end
    endtask

    task decode_byte(input t_in_item item);
        logic [6:0]  pos;
        int          k;
        logic [31:0] scaled;
        t_out_item   rec;
        if (item.frame_start) begin
            byte_pos = POS_ADDR;
        end
        pos = byte_pos;
        if (pos == POS_ADDR) begin
            frame_address = item.data_byte;
            frame_mode    = MODE_IGNORE;
            chan_idx      = '0;
        end else if (pos == POS_FUNC) begin
            frame_function = item.data_byte;
        end else if (pos == POS_COUNT) begin
            if (frame_address == ADDR_POWER && item.data_byte == COUNT_POWER) begin
                frame_mode = MODE_POWER;
                if (archive_cnt < ARCHIVE_CNT_MAX) begin
                    archive_cnt = archive_cnt + 8'd1;
                end
                if (archive_cnt >= archive_period) begin
                    archive_flag = 1'b1;
                    archive_cnt  = '0;
                end else begin
                    archive_flag = 1'b0;
                end
            end else if (frame_address == ADDR_RELAY && frame_function == FUNC_RELAY &&
                         item.data_byte == COUNT_RELAY) begin
                frame_mode = MODE_RELAY;
            end else begin
                frame_mode = MODE_IGNORE;
            end
        end else if (frame_mode == MODE_POWER) begin
            // offset inside the channel now being collected
            k = int'(pos) - FIRST_DATA_POS - int'(chan_idx) * CHAN_BYTES;
            if (k >= 0 && k < CHAN_BYTES) begin
                chan_bytes[k] = item.data_byte;
                if (k == CHAN_BYTES - 1) begin
                    rec                = '0;
                    rec.record_kind    = KIND_CHANNEL;
                    rec.channel        = {1'b0, chan_idx} + 4'd1;
                    scaled             = word_div(chan_bytes[0], chan_bytes[1], 32'd100);
                    rec.voltage        = scaled[9:0];
                    scaled             = word_div(chan_bytes[2], chan_bytes[3], 32'd1000);
                    rec.current        = scaled[6:0];
                    rec.apparent_power = {chan_bytes[4], chan_bytes[5]};
                    scaled             = {chan_bytes[6], chan_bytes[7],
                                          chan_bytes[8], chan_bytes[9]} / 32'd100;
                    rec.energy_total   = scaled[25:0];
                    scaled             = word_div(chan_bytes[10], chan_bytes[11], 32'd1000);
                    rec.power_factor   = scaled[6:0];
                    scaled             = word_div(chan_bytes[12], chan_bytes[13], 32'd100);
                    rec.frequency      = scaled[9:0];
                    rec.archive        = archive_flag;
                    decoded_records.push_back(rec);
                    if (int'(chan_idx) + 1 >= CHANNELS) begin
                        frame_mode = MODE_IGNORE;
                    end else begin
                        chan_idx = chan_idx + 3'd1;
                    end
                end
            end else begin
                frame_mode = MODE_IGNORE;
            end
        end else if (frame_mode == MODE_RELAY) begin
            rec             = '0;
            rec.record_kind = KIND_RELAY;
            rec.relay_bits  = item.data_byte;
            decoded_records.push_back(rec);
            frame_mode = MODE_IGNORE;
        end
        if (byte_pos < POS_MAX) begin
            byte_pos = byte_pos + 7'd1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            archive_period = ARCHIVE_PERIOD_RST;
            byte_pos       = POS_ADDR;
            frame_address  = '0;
            frame_function = '0;
            frame_mode     = MODE_IGNORE;
            chan_idx       = '0;
            archive_cnt    = '0;
            archive_flag   = 1'b0;
            decoded_records.delete();
        end else begin
            if (i_cfg_we) begin
                archive_period = i_cfg_wdata;
            end
            // a record leaves only after its last byte is registered, so check first
            if (i_out_valid && i_out_ready) begin
                if (decoded_records.size() == 0) begin
                    $error("record transfer with no record outstanding");
                    fails++;
                end else begin
                    want = decoded_records.pop_front();
                    compare_field("record_kind", want.record_kind, i_out_data.record_kind);
                    compare_field("channel", want.channel, i_out_data.channel);
                    compare_field("voltage", want.voltage, i_out_data.voltage);
                    compare_field("current", want.current, i_out_data.current);
                    compare_field("apparent_power", want.apparent_power,
                                  i_out_data.apparent_power);
                    compare_field("energy_total", want.energy_total, i_out_data.energy_total);
                    compare_field("power_factor", want.power_factor, i_out_data.power_factor);
                    compare_field("frequency", want.frequency, i_out_data.frequency);
                    compare_field("relay_bits", want.relay_bits, i_out_data.relay_bits);
                    compare_field("archive", want.archive, i_out_data.archive);
                    if (want.record_kind == KIND_RELAY) begin
                        relay_seen++;
                    end else begin
                        chan_seen++;
                    end
                    if (want.archive) begin
                        arch_seen++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data);
            end
        end
        o_fail_count       <= fails;
        o_pending          <= decoded_records.size();
        o_channel_records  <= chan_seen;
        o_relay_records    <= relay_seen;
        o_archived_records <= arch_seen;
    end

endmodule

// ===== tb/meter_reply_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// meter_reply_frame_decoder_tb
// feeds the frame decoder with directed frames and then random frame traffic
// in six phases with different archive periods and idle patterns; a record
// checker beside the block predicts and compares every record
// ----------------------------------------------------------------------------
module meter_reply_frame_decoder_tb;
    import mrfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } t_fill;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    t_in_item   i_data      = '0;
    logic       i_ready     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       o_ready;
    logic       o_valid;
    t_out_item  o_data;

    int fail_count;
    int pending;
    int channel_records;
    int relay_records;
    int archived_records;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_request  = 1'b0;
    logic hold_served   = 1'b0;
    int   hold_left     = 0;
    int   bytes_sent    = 0;
    int   cycle_count   = 0;

    meter_reply_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mrfd_record_checker record_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_in_data          (i_data),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_out_data         (o_data),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_channel_records  (channel_records),
        .o_relay_records    (relay_records),
        .o_archived_records (archived_records)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // record side: random stalls, plus one long hold-off to fill the block
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    task automatic send_item(input logic [7:0] value, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_data  <= {value, start};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // header of three bytes, then data_len data bytes (trailer bytes included)
    task automatic send_frame(input logic start, input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] count, input t_fill fill, input int data_len);
        logic [7:0] value;
        int         i;
        send_item(addr, start);
        send_item(func, 1'b0);
        send_item(count, 1'b0);
        for (i = 0; i < data_len; i++) begin
            case (fill)
                FILL_ONES:  value = 8'hFF;
                FILL_ZEROS: value = 8'h00;
                default:    value = rand_byte();
            endcase
            send_item(value, 1'b0);
        end
    endtask

    task automatic run_random_phase(input int n_bytes);
        int         stop_at;
        int         pick;
        int         len;
        int         i;
        t_fill      fill;
        logic [7:0] count;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                // mostly whole power frames, some cut short, some with trailer bytes
                if ($urandom_range(99) < 15) begin
                    len = $urandom_range(int'(COUNT_POWER) - 1);
                end else begin
                    len = int'(COUNT_POWER) + $urandom_range(4);
                end
                fill = ($urandom_range(19) == 0) ? FILL_ONES : FILL_RANDOM;
                send_frame($urandom_range(19) != 0, ADDR_POWER, rand_byte(), COUNT_POWER,
                           fill, len);
            end else if (pick < 72) begin
                send_frame($urandom_range(19) != 0, ADDR_RELAY, FUNC_RELAY, COUNT_RELAY,
                           FILL_RANDOM, 1 + $urandom_range(3));
            end else if (pick < 86) begin
                case ($urandom_range(2))
                    0:       count = COUNT_POWER;
                    1:       count = COUNT_RELAY;
                    default: count = rand_byte();
                endcase
                send_frame(1'b1, rand_byte() & 8'h03, rand_byte() & 8'h03, count,
                           FILL_RANDOM, $urandom_range(20));
            end else begin
                len = 1 + $urandom_range(11);
                for (i = 0; i < len; i++) begin
                    send_item(rand_byte(), $urandom_range(3) == 0);
                end
            end
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [7:0] seg_period [6];
        int         seg;
        seg_period[0] = 8'd1;
        seg_period[1] = ARCHIVE_CNT_MAX;
        seg_period[2] = 8'd0;
        seg_period[3] = 8'd3;
        seg_period[4] = rand_byte() | 8'h01;
        seg_period[5] = ARCHIVE_PERIOD_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_period(8'd2);
        send_idle_pct = 16;
        recv_idle_pct = 61;

        // relay frame straight after reset, address byte without frame start
        send_frame(1'b0, ADDR_RELAY, FUNC_RELAY, COUNT_RELAY, FILL_RANDOM, 1);
        send_frame(1'b1, ADDR_POWER, 8'h03, COUNT_POWER, FILL_ONES, int'(COUNT_POWER) + 2);
        send_frame(1'b1, ADDR_POWER, 8'h00, COUNT_POWER, FILL_ZEROS, int'(COUNT_POWER));
        send_frame(1'b1, ADDR_RELAY, FUNC_RELAY, COUNT_RELAY, FILL_ONES, 1);
        send_frame(1'b1, ADDR_RELAY, FUNC_RELAY, COUNT_RELAY, FILL_ZEROS, 3);
        // near misses of both headers
        send_frame(1'b1, ADDR_RELAY, 8'h00, COUNT_RELAY, FILL_RANDOM, 2);
        send_frame(1'b1, ADDR_RELAY, FUNC_RELAY, COUNT_POWER, FILL_RANDOM, 2);
        send_frame(1'b1, 8'h03, FUNC_RELAY, COUNT_RELAY, FILL_RANDOM, 2);
        send_frame(1'b1, ADDR_POWER, FUNC_RELAY, COUNT_POWER - 8'd1, FILL_RANDOM, 16);
        // cut short inside the third channel, then a frame long enough to saturate
        send_frame(1'b1, ADDR_POWER, rand_byte(), COUNT_POWER, FILL_RANDOM, 40);
        send_frame(1'b1, ADDR_POWER, rand_byte(), COUNT_POWER, FILL_RANDOM, 140);
        wait_idle();

        for (seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (seg == 4) begin
                hold_request = 1'b1;
            end
            write_period(seg_period[seg]);
            run_random_phase(PHASE_BYTES);
            wait_idle();
        end

        $display("%0d bytes sent: directed frames, then six random phases with archive periods",
                 bytes_sent);
        $display("from 0 to 255; %0d channel and %0d relay records checked, %0d archived",
                 channel_records, relay_records, archived_records);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
